// ----- rtl/ctb_pkg.sv -----
// ctb_pkg: shared constants for the countdown timer bank.
// Function codes, run-state codes and field widths; no dependencies.
`default_nettype none

package ctb_pkg;

   localparam int unsigned NUM_TIMERS_DEF = 8;

   localparam int unsigned FUNC_W  = 3;
   localparam int unsigned INDEX_W = 3;
   localparam int unsigned COUNT_W = 32;
   localparam int unsigned MODE_W  = 2;

   // item function codes
   localparam logic [FUNC_W-1:0] FUNC_TICK       = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_START_ONCE = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_RESTART    = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_STOP       = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_PAUSE      = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_RESUME     = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_READ_COUNT = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_TAKE_READY = 3'd7;

   // timer run states
   localparam logic [MODE_W-1:0] MODE_STOPPED = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RUNNING = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PAUSED  = 2'd2;

   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [MODE_W-1:0]  mode_type;

endpackage : ctb_pkg

`default_nettype wire

// ----- rtl/ctb_channels.sv -----
// ctb_channels: valid/ready channel interfaces for the timer bank.
// Depends on ctb_pkg for field widths.
`default_nettype none

interface ctb_req_if;
   import ctb_pkg::*;

   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [INDEX_W-1:0]  timer_index;
   logic [COUNT_W-1:0]  initial_count;

   modport source (output valid, func, timer_index, initial_count, input ready);
   modport sink   (input valid, func, timer_index, initial_count, output ready);
endinterface : ctb_req_if

interface ctb_rsp_if;
   import ctb_pkg::*;

   logic                valid;
   logic                ready;
   logic [COUNT_W-1:0]  count;
   logic                ready_res;
   logic [MODE_W-1:0]   run_state;

   modport source (output valid, count, ready_res, run_state, input ready);
   modport sink   (input valid, count, ready_res, run_state, output ready);
endinterface : ctb_rsp_if

`default_nettype wire

// ----- rtl/countdown_timer_bank.sv -----
// countdown_timer_bank: bank of NUM_TIMERS 32-bit countdown timers.
// Depends on ctb_pkg and the ctb_req_if / ctb_rsp_if channel interfaces.
// An accepted item's result sits in the output register in the cycle after.
// Throughput: one item per cycle unless results stall; timer state updates
// at the accept edge and the output register frees whenever results are taken.
// Reset (synchronous, active high): all counts zero, all timers stopped,
// ready flags clear, output register empty.
`default_nettype none

module countdown_timer_bank #(
   parameter int unsigned NUM_TIMERS = ctb_pkg::NUM_TIMERS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   ctb_req_if.sink   req_chan,
   ctb_rsp_if.source rsp_chan
);
   import ctb_pkg::*;

   // ---------------------------------------------------------------------
   // Timer state: one count, run state and ready flag per timer
   // ---------------------------------------------------------------------
   count_type counts_ff [NUM_TIMERS];
   count_type counts_in [NUM_TIMERS];
   mode_type  modes_ff  [NUM_TIMERS];
   mode_type  modes_in  [NUM_TIMERS];
   logic      ready_ff  [NUM_TIMERS];
   logic      ready_in  [NUM_TIMERS];

   // result register
   logic      rsp_valid_ff, rsp_valid_in;
   count_type rsp_count_ff, rsp_count_in;
   logic      rsp_rdy_ff,   rsp_rdy_in;
   mode_type  rsp_mode_ff,  rsp_mode_in;

   logic      req_accept;
   logic      idx_ok;     // index addresses an existing timer

   // Input side may take an item whenever the output register is empty
   // or is being drained in this same cycle.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign idx_ok         = 32'(req_chan.timer_index) < NUM_TIMERS;

   // ---------------------------------------------------------------------
   // Next state. A tick decrements every running timer in parallel; any
   // other function touches only the addressed timer.
   // ---------------------------------------------------------------------
   always_comb begin
      logic      hit;
      count_type dec;
      for (int t = 0; t < int'(NUM_TIMERS); t++) begin
         counts_in[t] = counts_ff[t];
         modes_in[t]  = modes_ff[t];
         ready_in[t]  = ready_ff[t];
         hit = req_accept && idx_ok && (32'(req_chan.timer_index) == 32'(t));
         dec = counts_ff[t] - 32'd1;
         if (req_accept && (req_chan.func == FUNC_TICK)) begin
            if (modes_ff[t] == MODE_RUNNING) begin
               // a running zero count wraps and keeps going
               counts_in[t] = dec;
               if (dec == '0) begin
                  ready_in[t] = 1'b1;
                  modes_in[t] = MODE_STOPPED;
               end
            end
         end else if (hit) begin
            unique case (req_chan.func)
               FUNC_START_ONCE: begin
                  if (modes_ff[t] != MODE_RUNNING) begin
                     counts_in[t] = req_chan.initial_count;
                     modes_in[t]  = MODE_RUNNING;
                  end
               end
               FUNC_RESTART: begin
                  counts_in[t] = req_chan.initial_count;
                  modes_in[t]  = MODE_RUNNING;
               end
               FUNC_STOP: begin
                  modes_in[t] = MODE_STOPPED;
                  ready_in[t] = 1'b0;
               end
               FUNC_PAUSE:      modes_in[t] = MODE_PAUSED;
               FUNC_RESUME:     modes_in[t] = MODE_RUNNING;
               FUNC_TAKE_READY: ready_in[t] = 1'b0;
               default: ;
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result: the addressed timer after the step. take_ready reports the
   // flag as it stood before clearing. A bad index reports all zero.
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_count_in = '0;
      rsp_rdy_in   = 1'b0;
      rsp_mode_in  = MODE_STOPPED;
      for (int t = 0; t < int'(NUM_TIMERS); t++) begin
         if (idx_ok && (32'(req_chan.timer_index) == 32'(t))) begin
            rsp_count_in = counts_in[t];
            rsp_rdy_in   = (req_chan.func == FUNC_TAKE_READY) ? ready_ff[t] : ready_in[t];
            rsp_mode_in  = modes_in[t];
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < int'(NUM_TIMERS); t++) begin
            counts_ff[t] <= '0;
            modes_ff[t]  <= MODE_STOPPED;
            ready_ff[t]  <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int t = 0; t < int'(NUM_TIMERS); t++) begin
            counts_ff[t] <= counts_in[t];
            modes_ff[t]  <= modes_in[t];
            ready_ff[t]  <= ready_in[t];
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload needs no reset; loads only on accept
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_count_ff <= rsp_count_in;
         rsp_rdy_ff   <= rsp_rdy_in;
         rsp_mode_ff  <= rsp_mode_in;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.count     = rsp_count_ff;
   assign rsp_chan.ready_res = rsp_rdy_ff;
   assign rsp_chan.run_state = rsp_mode_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("result register not empty after reset");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted item left no result");

   a_stop_result: assert property (@(posedge clock) disable iff (reset)
      (req_accept && idx_ok && (req_chan.func == FUNC_STOP))
      |=> (rsp_mode_ff == MODE_STOPPED) && !rsp_rdy_ff)
      else $error("stop did not report a stopped, not-ready timer");

   a_restart_load: assert property (@(posedge clock) disable iff (reset)
      (req_accept && idx_ok && (req_chan.func == FUNC_RESTART))
      |=> (rsp_count_ff == $past(req_chan.initial_count)) && (rsp_mode_ff == MODE_RUNNING))
      else $error("restart did not load the count");

endmodule : countdown_timer_bank

`default_nettype wire

// ----- verif/timer_bank_monitor.sv -----
// timer_bank_monitor: watches the item and result channels of the timer bank,
// predicts each result from its own copy of the timer state and compares.
// Depends on ctb_pkg and the ctb_req_if / ctb_rsp_if interfaces.
module timer_bank_monitor #(
   parameter int unsigned NUM_TIMERS = ctb_pkg::NUM_TIMERS_DEF
) (
   input  logic clock,
   input  logic reset,
   ctb_req_if   req_mon,
   ctb_rsp_if   rsp_mon,
   output int   failures,
   output int   reports_due
);
   timeunit 1ns;
   timeprecision 1ps;

   import ctb_pkg::*;

   typedef struct packed {
      count_type count;
      logic      ready_res;
      mode_type  run_state;
   } timer_report;

   count_type timer_count [NUM_TIMERS];
   mode_type  timer_mode  [NUM_TIMERS];
   logic      timer_flag  [NUM_TIMERS];

   timer_report expected_reports[$];

   // Applies one item to the shadow timers and returns what the bank reports.
   function automatic timer_report predict_timer_step(input logic [FUNC_W-1:0] fn,
                                                      input logic [INDEX_W-1:0] idx,
                                                      input count_type load);
      timer_report rep;
      logic        addressed;
      logic        flag_before;
      addressed   = (int'(idx) < int'(NUM_TIMERS));
      flag_before = 1'b0;
      if (fn == FUNC_TICK) begin
         for (int t = 0; t < int'(NUM_TIMERS); t++) begin
            if (timer_mode[t] == MODE_RUNNING) begin
               timer_count[t] = timer_count[t] - 32'd1;
               if (timer_count[t] == '0) begin
                  timer_flag[t] = 1'b1;
                  timer_mode[t] = MODE_STOPPED;
               end
            end
         end
      end else if (addressed) begin
         case (fn)
            FUNC_START_ONCE: begin
               if (timer_mode[idx] != MODE_RUNNING) begin
                  timer_count[idx] = load;
                  timer_mode[idx]  = MODE_RUNNING;
               end
            end
            FUNC_RESTART: begin
               timer_count[idx] = load;
               timer_mode[idx]  = MODE_RUNNING;
            end
            FUNC_STOP: begin
               timer_mode[idx] = MODE_STOPPED;
               timer_flag[idx] = 1'b0;
            end
            FUNC_PAUSE:  timer_mode[idx] = MODE_PAUSED;
            FUNC_RESUME: timer_mode[idx] = MODE_RUNNING;
            FUNC_TAKE_READY: begin
               flag_before     = timer_flag[idx];
               timer_flag[idx] = 1'b0;
            end
            default: ;
         endcase
      end
      rep = '0;
      if (addressed) begin
         rep.count     = timer_count[idx];
         rep.ready_res = (fn == FUNC_TAKE_READY) ? flag_before : timer_flag[idx];
         rep.run_state = timer_mode[idx];
      end
      return rep;
   endfunction

   function automatic void log_mismatch(input string what, input timer_report want,
                                        input timer_report got);
      failures++;
      if (failures <= 10)
         $display("%0t: %s: expected count %h ready %0d state %0d, %s %h ready %0d state %0d",
                  $time, what, want.count, want.ready_res, want.run_state,
                  "got count", got.count, got.ready_res, got.run_state);
   endfunction

   always @(posedge clock) begin
      timer_report got;
      timer_report want;
      if (reset) begin
         for (int t = 0; t < int'(NUM_TIMERS); t++) begin
            timer_count[t] = '0;
            timer_mode[t]  = MODE_STOPPED;
            timer_flag[t]  = 1'b0;
         end
         expected_reports.delete();
         failures = 0;
      end else begin
         // result first: it always belongs to an item taken at an earlier edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.count     = rsp_mon.count;
            got.ready_res = rsp_mon.ready_res;
            got.run_state = rsp_mon.run_state;
            if (expected_reports.size() == 0) begin
               log_mismatch("result with no item pending", '0, got);
            end else begin
               want = expected_reports.pop_front();
               if (got.count !== want.count || got.ready_res !== want.ready_res ||
                   got.run_state !== want.run_state)
                  log_mismatch("result mismatch", want, got);
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_reports.push_back(predict_timer_step(req_mon.func, req_mon.timer_index,
                                                          req_mon.initial_count));
      end
      reports_due = expected_reports.size();
   end

endmodule : timer_bank_monitor

// ----- verif/testbench.sv -----
// testbench: stimulus and verdict for countdown_timer_bank.
// Depends on ctb_pkg, the channel interfaces, the block and timer_bank_monitor.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import ctb_pkg::*;

   localparam int RANDOM_ITEMS     = 950;
   localparam int LONG_HOLD_CYCLES = 100;

   logic clock;
   logic reset;
   int   failures;
   int   reports_due;

   // pacing controls shared by the stimulus and the result side
   bit   calm;          // no random idling on either side while set
   bit   hold_results;  // asks the result side for one long hold-off

   ctb_req_if req_chan ();
   ctb_rsp_if rsp_chan ();

   countdown_timer_bank #(
      .NUM_TIMERS (NUM_TIMERS_DEF)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   timer_bank_monitor #(
      .NUM_TIMERS (NUM_TIMERS_DEF)
   ) bank_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .failures    (failures),
      .reports_due (reports_due)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #4_000_000;
      $display("testbench: FAIL");
      $finish;
   end

   // Idle stretch length: mostly short, now and then a long one.
   function automatic int idle_length();
      if ($urandom_range(99) < 80)
         return $urandom_range(3, 1);
      return $urandom_range(30, 8);
   endfunction

   // Function mix leans on ticks so loaded timers actually run out.
   function automatic logic [FUNC_W-1:0] pick_func();
      int r;
      r = $urandom_range(99);
      if (r < 35) return FUNC_TICK;
      if (r < 45) return FUNC_START_ONCE;
      if (r < 57) return FUNC_RESTART;
      if (r < 63) return FUNC_STOP;
      if (r < 69) return FUNC_PAUSE;
      if (r < 77) return FUNC_RESUME;
      if (r < 87) return FUNC_READ_COUNT;
      return FUNC_TAKE_READY;
   endfunction

   // Mostly small loads (0 to 12; nonzero ones expire within a dozen ticks); some mid-size,
   // some near the top (wrap region), some fully random for bit coverage.
   function automatic count_type pick_load();
      int r;
      r = $urandom_range(99);
      if (r < 75) return count_type'($urandom_range(12));
      if (r < 86) return count_type'($urandom_range(2000));
      if (r < 92) return 32'hFFFF_FFFF - count_type'($urandom_range(3));
      return count_type'($urandom());
   endfunction

   // Result side: one ready decision per falling edge. Random stalls unless
   // calm; a requested long hold-off is counted out here, cycle by cycle.
   initial begin : result_pacing
      int stall_left;
      stall_left     = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_results) begin
            hold_results = 1'b0;
            stall_left   = LONG_HOLD_CYCLES;
         end else if (stall_left == 0 && !calm && $urandom_range(99) < 15) begin
            stall_left = idle_length();
         end
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Offers one item from a falling edge and returns at the falling edge after
   // it is taken, valid still high so the next item can follow back to back.
   task automatic send_item(input logic [FUNC_W-1:0] fn, input logic [INDEX_W-1:0] idx,
                            input count_type load);
      req_chan.valid         <= 1'b1;
      req_chan.func          <= fn;
      req_chan.timer_index   <= idx;
      req_chan.initial_count <= load;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   // Drops valid and waits until every predicted result has come back.
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (reports_due != 0);
   endtask

   initial begin : stimulus
      int gap;
      reset                  = 1'b1;
      calm                   = 1'b0;
      hold_results           = 1'b0;
      req_chan.valid         = 1'b0;
      req_chan.func          = FUNC_TICK;
      req_chan.timer_index   = '0;
      req_chan.initial_count = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // running from zero: wraps to all ones, no ready
      send_item(FUNC_RESTART, 3'd0, 32'h0);
      send_item(FUNC_TICK, 3'd0, 32'h0);
      // expiry: count to zero sets ready and stops; start_once while running is ignored
      send_item(FUNC_RESTART, 3'd1, 32'd2);
      send_item(FUNC_TICK, 3'd1, 32'h0);
      send_item(FUNC_START_ONCE, 3'd1, 32'd5);
      send_item(FUNC_TICK, 3'd1, 32'h0);
      send_item(FUNC_READ_COUNT, 3'd1, 32'h0);
      send_item(FUNC_TAKE_READY, 3'd1, 32'h0);
      send_item(FUNC_TAKE_READY, 3'd1, 32'h0);
      // pause of a stopped timer, then resume from zero count
      send_item(FUNC_PAUSE, 3'd2, 32'h0);
      send_item(FUNC_RESUME, 3'd2, 32'h0);
      send_item(FUNC_TICK, 3'd2, 32'h0);
      // start_once on a stopped timer loads; paused timer holds on a tick
      send_item(FUNC_START_ONCE, 3'd3, 32'hFFFF_FFFF);
      send_item(FUNC_PAUSE, 3'd3, 32'h0);
      send_item(FUNC_TICK, 3'd3, 32'h0);
      send_item(FUNC_RESUME, 3'd3, 32'h0);
      send_item(FUNC_TICK, 3'd3, 32'h0);
      // stop clears ready; start_once on stopped loads, restart overrides
      send_item(FUNC_RESTART, 3'd7, 32'd1);
      send_item(FUNC_TICK, 3'd7, 32'h0);
      send_item(FUNC_STOP, 3'd7, 32'h0);
      send_item(FUNC_START_ONCE, 3'd7, 32'hA5A5_A5A5);
      send_item(FUNC_RESTART, 3'd7, 32'h5A5A_5A5A);
      send_item(FUNC_READ_COUNT, 3'd7, 32'h0);
      send_item(FUNC_STOP, 3'd0, 32'h0);
      send_item(FUNC_READ_COUNT, 3'd6, 32'h0);
      drain_results();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         // every fourth block of 100 items runs with no random idling
         calm = ((i / 100) % 4 == 3);
         // long result hold-off while the sender keeps pushing: bank fills and stalls
         if (i == 300 || i == 720)
            hold_results = 1'b1;
         send_item(pick_func(), INDEX_W'($urandom_range(7)), pick_load());
         if (i == 500) begin
            drain_results();
         end else if (!calm && $urandom_range(99) < 20) begin
            gap = idle_length();
            req_chan.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end

      drain_results();
      // results are registered; extra edges catch any stray result
      repeat (4) @(posedge clock);
      if (failures == 0 && reports_due == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule : testbench
